/* hw/rtl/dbmf_pkg.sv */
// Shared types and constants for the debounced monoflop.
// No dependencies; used by dbmf_step and debounced_monoflop_top.
`default_nettype none

package dbmf_pkg;

   localparam int unsigned TimeWidth  = 32;
   localparam int unsigned DelayWidth = 16;
   localparam int unsigned IndexWidth = 3;

   // Register indexes on the csr port
   localparam logic [IndexWidth-1:0] RegHighDelay   = 3'd0;
   localparam logic [IndexWidth-1:0] RegLowDelay    = 3'd1;
   localparam logic [IndexWidth-1:0] RegDebounce    = 3'd2;
   localparam logic [IndexWidth-1:0] RegPressedLvl  = 3'd3;
   localparam logic [IndexWidth-1:0] RegAutoStart   = 3'd4;

   typedef enum logic [2:0] {
      PH_LOW      = 3'd0,
      PH_LOW_RUN  = 3'd1,
      PH_LOW_END  = 3'd2,
      PH_HIGH     = 3'd3,
      PH_HIGH_RUN = 3'd4,
      PH_HIGH_END = 3'd5
   } phase_type;

   typedef struct packed {
      logic [DelayWidth-1:0] high_delay_ms;
      logic [DelayWidth-1:0] low_delay_ms;
      logic [DelayWidth-1:0] debounce_ms;
      logic                  pressed_level;
      logic                  auto_start;
   } cfg_type;

   typedef struct packed {
      phase_type            mono_phase;
      logic [TimeWidth-1:0] timer_end;
      logic [TimeWidth-1:0] holdoff_until;
      logic                 pin_now;
      logic                 pin_before;
      logic                 startup_pending;
   } mono_state_type;

endpackage

`default_nettype wire

/* hw/rtl/debounced_monoflop_top.sv */
// Debounced monoflop with a one-poll-per-transaction stream interface.
// Depends on dbmf_pkg and dbmf_step.
//
// Each req transaction is one poll (time stamp and pin level) and yields
// exactly one rsp transaction with the new phase and a changed flag. A poll
// is registered on entry, then combinational compare/add logic updates the
// monoflop state and loads the rsp register; a new poll is accepted every
// cycle, limited only by rsp_tready. Registers are written via the csr port
// (always ready); the user must do so only while idle, which is not enforced.
`default_nettype none

module debounced_monoflop_top (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [31:0] now_ms, [32] pin_level, [39:33] zero
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,
   // rsp_tdata: [2:0] phase, [3] phase_changed, [7:4] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   // configuration writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dbmf_pkg::IndexWidth-1:0]     csr_index,
   input  logic [dbmf_pkg::DelayWidth-1:0]     csr_data
);

   dbmf_pkg::cfg_type                 cfg_ff;
   dbmf_pkg::mono_state_type          state_ff;
   dbmf_pkg::mono_state_type          state_in;
   logic                              in_valid_ff;
   logic [dbmf_pkg::TimeWidth-1:0]    in_now_ff;
   logic                              in_pin_ff;
   logic                              rsp_valid_ff;
   dbmf_pkg::phase_type               rsp_phase_ff;
   logic                              rsp_changed_ff;
   logic                              advance;

   // stage moves when the rsp register is free or being drained
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            dbmf_pkg::RegHighDelay:  cfg_ff.high_delay_ms <= csr_data;
            dbmf_pkg::RegLowDelay:   cfg_ff.low_delay_ms  <= csr_data;
            dbmf_pkg::RegDebounce:   cfg_ff.debounce_ms   <= csr_data;
            dbmf_pkg::RegPressedLvl: cfg_ff.pressed_level <= csr_data[0];
            dbmf_pkg::RegAutoStart:  cfg_ff.auto_start    <= csr_data[0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_now_ff <= req_tdata[dbmf_pkg::TimeWidth-1:0];
         in_pin_ff <= req_tdata[dbmf_pkg::TimeWidth];
      end
   end

   dbmf_step u_step (
      .cfg       (cfg_ff),
      .cur       (state_ff),
      .now_ms    (in_now_ff),
      .pin_level (in_pin_ff),
      .nxt       (state_in)
   );

   // monoflop state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mono_phase      <= dbmf_pkg::PH_LOW_END;
         state_ff.timer_end       <= '0;
         state_ff.holdoff_until   <= '0;
         state_ff.pin_now         <= 1'b0;
         state_ff.pin_before      <= 1'b0;
         state_ff.startup_pending <= 1'b1;
      end else if (in_valid_ff && advance) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_ff && advance) begin
         rsp_phase_ff   <= state_in.mono_phase;
         rsp_changed_ff <= state_in.mono_phase != state_ff.mono_phase;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_changed_ff, rsp_phase_ff};

endmodule

`default_nettype wire

/* hw/rtl/dbmf_step.sv */
// One poll of the debounced monoflop: next state from current state and a poll.
// Depends on dbmf_pkg.
`default_nettype none

module dbmf_step (
   input  dbmf_pkg::cfg_type                  cfg,
   input  dbmf_pkg::mono_state_type           cur,
   input  logic [dbmf_pkg::TimeWidth-1:0]     now_ms,
   input  logic                               pin_level,
   output dbmf_pkg::mono_state_type           nxt
);

   logic [dbmf_pkg::DelayWidth-1:0] high_hold;
   logic [dbmf_pkg::DelayWidth-1:0] low_hold;
   logic                            timer_passed;
   logic                            in_holdoff;

   // hold times floored to the debounce time
   assign high_hold = (cfg.high_delay_ms > cfg.debounce_ms) ? cfg.high_delay_ms
                                                             : cfg.debounce_ms;
   assign low_hold  = (cfg.low_delay_ms > cfg.debounce_ms) ? cfg.low_delay_ms
                                                            : cfg.debounce_ms;

   assign timer_passed = now_ms > cur.timer_end;
   assign in_holdoff   = cur.holdoff_until > now_ms;

   always_comb begin
      nxt            = cur;
      nxt.pin_before = cur.pin_now;
      case (cur.mono_phase)
         dbmf_pkg::PH_HIGH: begin
            nxt.mono_phase = dbmf_pkg::PH_HIGH_RUN;
            nxt.timer_end  = now_ms + {{(dbmf_pkg::TimeWidth-dbmf_pkg::DelayWidth){1'b0}},
                                       high_hold};
         end
         dbmf_pkg::PH_LOW: begin
            nxt.mono_phase = dbmf_pkg::PH_LOW_RUN;
            nxt.timer_end  = now_ms + {{(dbmf_pkg::TimeWidth-dbmf_pkg::DelayWidth){1'b0}},
                                       low_hold};
         end
         default: begin
            if (timer_passed && cur.mono_phase == dbmf_pkg::PH_LOW_RUN) begin
               nxt.mono_phase = dbmf_pkg::PH_LOW_END;
            end else if (timer_passed && cur.mono_phase == dbmf_pkg::PH_HIGH_RUN) begin
               nxt.mono_phase = dbmf_pkg::PH_HIGH_END;
            end else if (!in_holdoff) begin
               // pin is read
               nxt.pin_now = pin_level;
               if (cur.startup_pending && cfg.auto_start) begin
                  nxt.mono_phase      = pin_level ? dbmf_pkg::PH_HIGH_END : dbmf_pkg::PH_HIGH;
                  nxt.startup_pending = 1'b0;
               end else begin
                  if (pin_level != cur.pin_now) begin
                     nxt.holdoff_until = now_ms +
                        {{(dbmf_pkg::TimeWidth-dbmf_pkg::DelayWidth){1'b0}}, cfg.debounce_ms};
                  end
                  if (cur.mono_phase == dbmf_pkg::PH_LOW_END &&
                      pin_level == cfg.pressed_level) begin
                     nxt.mono_phase = dbmf_pkg::PH_HIGH;
                  end else if (cur.mono_phase == dbmf_pkg::PH_HIGH_END &&
                               pin_level != cfg.pressed_level) begin
                     nxt.mono_phase = dbmf_pkg::PH_LOW;
                  end
               end
            end
         end
      endcase
   end

endmodule

`default_nettype wire
